// ===== sv/cpeb_pkg.sv =====
// Package for the circle pair elastic bounce core: payload structs, pipeline
// stage map and the arithmetic step functions shared by the stages.
// Depends on nothing.
`default_nettype none

package cpeb_pkg;

    // Stage map of the pipeline
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int ST_IN      = 0;
    localparam int ST_SQ      = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_ROOT    = 3;
    localparam int ST_OV      = ST_ROOT + ROOT_STEPS;
    localparam int ST_PUSH    = ST_OV + 1;
    localparam int ST_PPROD   = ST_PUSH + 1;
    localparam int ST_DIV     = ST_PPROD + 1;
    localparam int ST_DOTM    = ST_DIV + DIV_STEPS;
    localparam int ST_DOTS    = ST_DOTM + 1;
    localparam int ST_NM      = ST_DOTS + 1;
    localparam int ST_NS      = ST_NM + 1;
    localparam int ST_WM      = ST_NS + 1;
    localparam int ST_WS      = ST_WM + 1;
    localparam int ST_OUT     = ST_WS + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // Divider lanes
    localparam int DV_AX    = 0;
    localparam int DV_AY    = 1;
    localparam int DV_BX    = 2;
    localparam int DV_BY    = 3;
    localparam int DV_UX    = 4;
    localparam int DV_UY    = 5;
    localparam int DV_LANES = 6;

    // Velocity weighting lanes
    localparam int WL_AX    = 0;
    localparam int WL_AY    = 1;
    localparam int WL_BX    = 2;
    localparam int WL_BY    = 3;
    localparam int WL_LANES = 4;

    localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic        [30:0] a_radius;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
        logic        [30:0] b_radius;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_a_pos_x;
        logic signed [31:0] new_a_pos_y;
        logic signed [31:0] new_a_vel_x;
        logic signed [31:0] new_a_vel_y;
        logic signed [31:0] new_b_pos_x;
        logic signed [31:0] new_b_pos_y;
        logic signed [31:0] new_b_vel_x;
        logic signed [31:0] new_b_vel_y;
        logic               collided;
        logic               coincident;
    } t_out;

    typedef struct packed {
        logic [63:0] r;
        logic [31:0] q;
    } t_frac;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] q;
    } t_div;

    // Everything one transaction carries down the pipeline
    typedef struct packed {
        t_in                              din;
        logic                             dx_neg;
        logic                             dy_neg;
        logic [32:0]                      adx;
        logic [32:0]                      ady;
        logic                             coinc;
        logic                             far;
        logic [31:0]                      s;
        logic [63:0]                      sx;
        logic [63:0]                      sy;
        logic [61:0]                      ma;
        logic [61:0]                      mb;
        logic [62:0]                      tot;
        logic [63:0]                      sq_x;
        logic [63:0]                      sq_r;
        t_frac                            fa;
        t_frac                            fb;
        logic                             collide;
        logic [31:0]                      ov;
        logic [31:0]                      pa;
        logic [31:0]                      pb;
        t_div [DV_LANES-1:0]              dv;
        logic signed [63:0]               pvx;
        logic signed [63:0]               pvy;
        logic signed [34:0]               dot;
        logic signed [65:0]               pnx;
        logic signed [65:0]               pny;
        logic                             nx_neg;
        logic                             ny_neg;
        logic [35:0]                      nx_m;
        logic [35:0]                      ny_m;
        logic [WL_LANES-1:0][62:0]        w_lo;
        logic [WL_LANES-1:0][36:0]        w_hi;
        logic [WL_LANES-1:0][35:0]        wm;
        t_out                             res;
    } t_work;

    // Clamp to the signed 32-bit range
    function automatic logic [31:0] f_sat(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Add or subtract a signed magnitude, then saturate
    function automatic logic signed [31:0] f_move(input logic signed [31:0] base,
                                                  input logic [37:0] m,
                                                  input logic neg,
                                                  input logic add);
        logic signed [39:0] d;
        logic signed [39:0] v;
        d = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        v = add ? (40'(base) + d) : (40'(base) - d);
        return $signed(f_sat(v));
    endfunction

    // One bit of the mass share fraction; the first step only compares
    function automatic t_frac f_frac_step(input t_frac p, input logic [62:0] den,
                                          input logic first);
        t_frac w;
        w.r = first ? p.r : {p.r[62:0], 1'b0};
        w.q = first ? 32'd0 : {p.q[30:0], 1'b0};
        if (w.r >= 64'(den)) begin
            w.r  = w.r - 64'(den);
            w.q[0] = 1'b1;
        end
        return w;
    endfunction

    // One quotient bit of a restoring division
    function automatic t_div f_div_step(input t_div p, input logic [32:0] den);
        t_div        w;
        logic [33:0] t;
        logic        ge;
        t  = {p.rem, p.q[31]};
        ge = (t >= 34'(den));
        w.rem = ge ? 33'(t - 34'(den)) : t[32:0];
        w.q   = {p.q[30:0], ge};
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cpeb_out_fifo.sv =====
// Two-entry output queue of the circle pair bounce core, parting the pipeline
// from the receiver's stall. Depends on cpeb_pkg.
`default_nettype none

module cpeb_out_fifo
    import cpeb_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_push,
    input  wire  t_out i_data,
    output logic       o_full,
    output logic       o_valid,
    input  wire  logic i_stall,
    output t_out       o_data
);

    t_out       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd];

    // Store the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full output queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("output queue count not reduced on pop");

endmodule

`default_nettype wire

// ===== sv/circle_pair_elastic_bounce_core.sv =====
// Circle pair elastic bounce: pushes two overlapping circles apart and
// exchanges their normal velocities. Depends on cpeb_pkg and cpeb_out_fifo.
//
// Usage: a transaction on the input channel (i_valid, o_stall, i_data) carries
// both circles; one result transaction per input leaves on the output channel
// (o_valid, i_stall, o_data), in order.
// Pipeline: the 32-step square root (run alongside the two mass share
// fractions) and the 32-step divider bank for the push distances and the
// unit normal, plus 13 arithmetic stages.
// Throughput: one transaction per cycle; every stage holds one transaction.
// The results drain into a two-entry queue, so the pipeline keeps moving
// while a result waits; o_stall rises only when that queue is full, and the
// whole pipeline then holds without losing or repeating anything.
// Reset: synchronous, active low; clears all valid bits and the queue.
`default_nettype none

module circle_pair_elastic_bounce_core
    import cpeb_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_valid,
    output logic       o_stall,
    input  wire  t_in  i_data,
    output logic       o_valid,
    input  wire  logic i_stall,
    output t_out       o_data
);

    // Capture the offsets and the special cases
    function automatic t_work f_load(input t_in d);
        t_work             w;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        w     = '0;
        w.din = d;
        dx = 33'(d.b_pos_x) - 33'(d.a_pos_x);
        dy = 33'(d.b_pos_y) - 33'(d.a_pos_y);
        w.dx_neg = dx[32];
        w.dy_neg = dy[32];
        w.adx    = dx[32] ? 33'(-dx) : 33'(dx);
        w.ady    = dy[32] ? 33'(-dy) : 33'(dy);
        w.coinc  = (dx == 33'sd0) && (dy == 33'sd0);
        w.far    = w.adx[32] || w.ady[32];
        w.s      = 32'(d.a_radius) + 32'(d.b_radius);
        return w;
    endfunction

    // Work of one pipeline stage
    function automatic t_work f_step(input t_work p, input int k);
        t_work              w;
        int                 i;
        logic [63:0]        bt;
        logic [63:0]        t64;
        logic [64:0]        d2;
        logic [31:0]        root_d;
        logic [32:0]        den;
        logic [63:0]        num [DV_LANES];
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic [30:0]        umx;
        logic [30:0]        umy;
        logic signed [30:0] ux;
        logic signed [30:0] uy;
        logic signed [64:0] sum;
        logic [64:0]        sm;
        logic [33:0]        dm;
        logic [65:0]        am;
        logic [35:0]        nm;
        logic [31:0]        wt;
        w      = p;
        root_d = p.sq_r[31:0];
        umx    = {1'b0, p.dv[DV_UX].q[29:0]};
        umy    = {1'b0, p.dv[DV_UY].q[29:0]};
        ux     = p.dx_neg ? -$signed(umx) : $signed(umx);
        uy     = p.dy_neg ? -$signed(umy) : $signed(umy);

        if (k == ST_SQ) begin
            // squares of the offsets and of the radii
            w.sx = 64'(p.adx[31:0]) * 64'(p.adx[31:0]);
            w.sy = 64'(p.ady[31:0]) * 64'(p.ady[31:0]);
            w.ma = 62'(p.din.a_radius) * 62'(p.din.a_radius);
            w.mb = 62'(p.din.b_radius) * 62'(p.din.b_radius);
        end else if (k == ST_SUM) begin
            // squared distance, total mass, seed the root and fractions
            d2     = 65'(p.sx) + 65'(p.sy);
            w.far  = p.far || d2[64];
            w.sq_x = d2[63:0];
            w.sq_r = '0;
            w.tot  = 63'(p.ma) + 63'(p.mb);
            w.fa.r = 64'(p.ma);
            w.fa.q = '0;
            w.fb.r = 64'(p.mb);
            w.fb.q = '0;
        end else if (k >= ST_ROOT && k < ST_OV) begin
            // one bit of the root and of both mass shares
            i   = k - ST_ROOT;
            bt  = 64'd1 << (62 - 2 * i);
            t64 = p.sq_r + bt;
            if (p.sq_x >= t64) begin
                w.sq_x = p.sq_x - t64;
                w.sq_r = (p.sq_r >> 1) + bt;
            end else begin
                w.sq_r = p.sq_r >> 1;
            end
            w.fa = f_frac_step(p.fa, p.tot, (i == 0));
            w.fb = f_frac_step(p.fb, p.tot, (i == 0));
        end else if (k == ST_OV) begin
            w.collide = !p.coinc && !p.far && (p.s > root_d);
            w.ov      = p.s - root_d;
        end else if (k == ST_PUSH) begin
            // push lengths weighted by mass share
            w.pa = 32'((64'(p.ov) * 64'(p.fa.q)) >> 31);
            w.pb = 32'((64'(p.ov) * 64'(p.fb.q)) >> 31);
        end else if (k == ST_PPROD) begin
            // dividends for the push components and the unit normal
            num[DV_AX] = 64'(p.pa) * 64'(p.adx[31:0]);
            num[DV_AY] = 64'(p.pa) * 64'(p.ady[31:0]);
            num[DV_BX] = 64'(p.pb) * 64'(p.adx[31:0]);
            num[DV_BY] = 64'(p.pb) * 64'(p.ady[31:0]);
            num[DV_UX] = 64'(p.adx[31:0]) << 29;
            num[DV_UY] = 64'(p.ady[31:0]) << 29;
            for (int l = 0; l < DV_LANES; l++) begin
                w.dv[l].rem = 33'(num[l][63:32]);
                w.dv[l].q   = num[l][31:0];
            end
        end else if (k >= ST_DIV && k < ST_DOTM) begin
            // push lanes divide by twice the distance, normal lanes by it
            for (int l = 0; l < DV_LANES; l++) begin
                den = (l < DV_UX) ? {root_d, 1'b0} : {1'b0, root_d};
                w.dv[l] = f_div_step(p.dv[l], den);
            end
        end else if (k == ST_DOTM) begin
            dvx   = 33'(p.din.a_vel_x) - 33'(p.din.b_vel_x);
            dvy   = 33'(p.din.a_vel_y) - 33'(p.din.b_vel_y);
            w.pvx = 64'(dvx) * 64'(ux);
            w.pvy = 64'(dvy) * 64'(uy);
        end else if (k == ST_DOTS) begin
            // relative speed along the normal, truncated toward zero
            sum   = 65'(p.pvx) + 65'(p.pvy);
            sm    = sum[64] ? 65'(-sum) : 65'(sum);
            dm    = 34'(sm >> 29);
            w.dot = sum[64] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
        end else if (k == ST_NM) begin
            w.pnx = 66'(p.dot) * 66'(ux);
            w.pny = 66'(p.dot) * 66'(uy);
        end else if (k == ST_NS) begin
            w.nx_neg = p.pnx[65];
            w.ny_neg = p.pny[65];
            am       = p.pnx[65] ? 66'(-p.pnx) : 66'(p.pnx);
            w.nx_m   = 36'(am >> 29);
            am       = p.pny[65] ? 66'(-p.pny) : 66'(p.pny);
            w.ny_m   = 36'(am >> 29);
        end else if (k == ST_WM) begin
            // split products of the normal with the other circle's share
            for (int l = 0; l < WL_LANES; l++) begin
                nm = (l == WL_AY || l == WL_BY) ? p.ny_m : p.nx_m;
                wt = (l == WL_AX || l == WL_AY) ? p.fb.q : p.fa.q;
                w.w_lo[l] = 63'(nm[30:0]) * 63'(wt);
                w.w_hi[l] = 37'(nm[35:31]) * 37'(wt);
            end
        end else if (k == ST_WS) begin
            for (int l = 0; l < WL_LANES; l++) begin
                w.wm[l] = 36'(64'(p.w_hi[l]) + 64'(p.w_lo[l] >> 31));
            end
        end else if (k == ST_OUT) begin
            // apply the response, or pass the circles through
            w.res.new_a_pos_x = p.din.a_pos_x;
            w.res.new_a_pos_y = p.din.a_pos_y;
            w.res.new_a_vel_x = p.din.a_vel_x;
            w.res.new_a_vel_y = p.din.a_vel_y;
            w.res.new_b_pos_x = p.din.b_pos_x;
            w.res.new_b_pos_y = p.din.b_pos_y;
            w.res.new_b_vel_x = p.din.b_vel_x;
            w.res.new_b_vel_y = p.din.b_vel_y;
            w.res.collided    = p.collide;
            w.res.coincident  = p.coinc;
            if (p.collide) begin
                w.res.new_a_pos_x = f_move(p.din.a_pos_x, 38'(p.dv[DV_AX].q),
                                           p.dx_neg, 1'b0);
                w.res.new_a_pos_y = f_move(p.din.a_pos_y, 38'(p.dv[DV_AY].q),
                                           p.dy_neg, 1'b0);
                w.res.new_b_pos_x = f_move(p.din.b_pos_x, 38'(p.dv[DV_BX].q),
                                           p.dx_neg, 1'b1);
                w.res.new_b_pos_y = f_move(p.din.b_pos_y, 38'(p.dv[DV_BY].q),
                                           p.dy_neg, 1'b1);
                w.res.new_a_vel_x = f_move(p.din.a_vel_x, {1'b0, p.wm[WL_AX], 1'b0},
                                           p.nx_neg, 1'b0);
                w.res.new_a_vel_y = f_move(p.din.a_vel_y, {1'b0, p.wm[WL_AY], 1'b0},
                                           p.ny_neg, 1'b0);
                w.res.new_b_vel_x = f_move(p.din.b_vel_x, {1'b0, p.wm[WL_BX], 1'b0},
                                           p.nx_neg, 1'b1);
                w.res.new_b_vel_y = f_move(p.din.b_vel_y, {1'b0, p.wm[WL_BY], 1'b0},
                                           p.ny_neg, 1'b1);
            end
        end
        return w;
    endfunction

    t_work                 r_pipe [NUM_STAGES];
    t_work                 n_pipe [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_vld;
    logic                  en;
    logic                  q_full;

    // Whole pipeline moves while the output queue has room
    assign en      = !q_full;
    assign o_stall = !en;

    assign n_pipe[0] = f_load(i_data);

    for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
        assign n_pipe[k] = f_step(r_pipe[k-1], k);
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pipe <= n_pipe;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_valid};
        end
    end

    cpeb_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && r_vld[NUM_STAGES-1]),
        .i_data  (r_pipe[NUM_STAGES-1].res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.collided && o_data.coincident))
        else $error("collided and coincident both set");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid bits moved while pipeline held");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

endmodule

`default_nettype wire

// ===== test/cpeb_checker.sv =====
// Checker for the circle pair elastic bounce core: watches both channels,
// predicts each result from the accepted input and compares in order.
// Depends on cpeb_pkg for the payload structs.
`default_nettype none

module cpeb_checker
    import cpeb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_stall,
    input  wire t_in  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_stall,
    input  wire t_out i_out_data,
    output int        o_errors,
    output int        o_pending
);

    t_out bounce_q[$];

    // Magnitude with a sign applied
    function automatic longint signed_mag(input logic [63:0] m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Signed divide by 2^sh, truncated toward zero
    function automatic longint trunc_shift(input longint v, input int sh);
        return signed_mag(abs64(v) >> sh, v < 0);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Work out the separated positions and exchanged velocities of a pair
    function automatic t_out bounce(input t_in c);
        t_out o;
        longint ax, ay, bx, by, avx, avy, bvx, bvy, dx, dy;
        longint ux, uy, dot, nx, ny;
        logic [63:0] adx, ady, s, cdist, ov, ma, mb, tot, wa, wb, pa, pb;
        logic [127:0] d2;
        ax = longint'(c.a_pos_x); ay = longint'(c.a_pos_y);
        bx = longint'(c.b_pos_x); by = longint'(c.b_pos_y);
        avx = longint'(c.a_vel_x); avy = longint'(c.a_vel_y);
        bvx = longint'(c.b_vel_x); bvy = longint'(c.b_vel_y);
        dx = bx - ax;
        dy = by - ay;
        adx = abs64(dx);
        ady = abs64(dy);
        s = 64'(c.a_radius) + 64'(c.b_radius);
        o = '{c.a_pos_x, c.a_pos_y, c.a_vel_x, c.a_vel_y,
              c.b_pos_x, c.b_pos_y, c.b_vel_x, c.b_vel_y, 1'b0, 1'b0};
        if (dx == 0 && dy == 0) begin
            o.coincident = 1'b1;
            return o;
        end
        if (adx >= 64'h1_0000_0000 || ady >= 64'h1_0000_0000) return o;
        d2 = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
        if (d2 >= (128'd1 << 64)) return o;
        cdist = root64(d2[63:0]);
        if (s <= cdist) return o;
        ov  = s - cdist;
        ma  = 64'(c.a_radius) * 64'(c.a_radius);
        mb  = 64'(c.b_radius) * 64'(c.b_radius);
        tot = ma + mb;
        wa  = 64'((128'(ma) << 31) / 128'(tot));
        wb  = 64'((128'(mb) << 31) / 128'(tot));
        pa  = (ov * wa) >> 31;
        pb  = (ov * wb) >> 31;
        o.new_a_pos_x = clamp32(ax - signed_mag((pa * adx) / (2 * cdist), dx < 0));
        o.new_a_pos_y = clamp32(ay - signed_mag((pa * ady) / (2 * cdist), dy < 0));
        o.new_b_pos_x = clamp32(bx + signed_mag((pb * adx) / (2 * cdist), dx < 0));
        o.new_b_pos_y = clamp32(by + signed_mag((pb * ady) / (2 * cdist), dy < 0));
        ux  = signed_mag((adx << 29) / cdist, dx < 0);
        uy  = signed_mag((ady << 29) / cdist, dy < 0);
        dot = trunc_shift((avx - bvx) * ux + (avy - bvy) * uy, 29);
        nx  = trunc_shift(dot * ux, 29);
        ny  = trunc_shift(dot * uy, 29);
        o.new_a_vel_x = clamp32(avx - signed_mag(
            2 * 64'((128'(abs64(nx)) * 128'(wb)) >> 31), nx < 0));
        o.new_a_vel_y = clamp32(avy - signed_mag(
            2 * 64'((128'(abs64(ny)) * 128'(wb)) >> 31), ny < 0));
        o.new_b_vel_x = clamp32(bvx + signed_mag(
            2 * 64'((128'(abs64(nx)) * 128'(wa)) >> 31), nx < 0));
        o.new_b_vel_y = clamp32(bvy + signed_mag(
            2 * 64'((128'(abs64(ny)) * 128'(wa)) >> 31), ny < 0));
        o.collided = 1'b1;
        return o;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = bounce_q.size();

    // Queue predictions on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_out w;
        t_out g;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) bounce_q = {bounce_q, bounce(i_in_data)};
            if (i_out_valid && !i_out_stall) begin
                g = i_out_data;
                if (bounce_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    w = bounce_q.pop_front();
                    if (g.new_a_pos_x !== w.new_a_pos_x)
                        report("new_a_pos_x", g.new_a_pos_x, w.new_a_pos_x);
                    if (g.new_a_pos_y !== w.new_a_pos_y)
                        report("new_a_pos_y", g.new_a_pos_y, w.new_a_pos_y);
                    if (g.new_a_vel_x !== w.new_a_vel_x)
                        report("new_a_vel_x", g.new_a_vel_x, w.new_a_vel_x);
                    if (g.new_a_vel_y !== w.new_a_vel_y)
                        report("new_a_vel_y", g.new_a_vel_y, w.new_a_vel_y);
                    if (g.new_b_pos_x !== w.new_b_pos_x)
                        report("new_b_pos_x", g.new_b_pos_x, w.new_b_pos_x);
                    if (g.new_b_pos_y !== w.new_b_pos_y)
                        report("new_b_pos_y", g.new_b_pos_y, w.new_b_pos_y);
                    if (g.new_b_vel_x !== w.new_b_vel_x)
                        report("new_b_vel_x", g.new_b_vel_x, w.new_b_vel_x);
                    if (g.new_b_vel_y !== w.new_b_vel_y)
                        report("new_b_vel_y", g.new_b_vel_y, w.new_b_vel_y);
                    if (g.collided !== w.collided)
                        report("collided", g.collided, w.collided);
                    if (g.coincident !== w.coincident)
                        report("coincident", g.coincident, w.coincident);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench top for the circle pair elastic bounce core: drives circle pairs
// with random idling and back-pressure and gives the verdict.
// Depends on cpeb_pkg, circle_pair_elastic_bounce_core and cpeb_checker.
`default_nettype none

module tb;
    import cpeb_pkg::*;

    localparam int IN_W = $bits(t_in);

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;
    int   errors;
    int   pending;
    int   sent;
    bit   calm;
    bit   hold_req;

    circle_pair_elastic_bounce_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    cpeb_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop the run if it hangs
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                n = 0;
                while (n < 300) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                    n++;
                end
            end
            i_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
        end
    end

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    // Well-formed overlapping pair at a random scale
    function automatic t_in overlap_pair();
        t_in c;
        int          sh;
        longint      off;
        sh = $urandom_range(0, 14);
        c.a_radius = 31'($urandom_range(1, 32'h7FFF) << sh);
        c.b_radius = 31'($urandom_range(1, 32'h7FFF) << sh);
        off = longint'(c.a_radius) + longint'(c.b_radius);
        c.a_pos_x = $urandom_range(0, 3) == 0 ? rnd32() : 32'($signed($urandom) >>> 3);
        c.a_pos_y = 32'($signed($urandom) >>> 3);
        c.b_pos_x = 32'(longint'(c.a_pos_x) + ($urandom % off) - off / 2);
        c.b_pos_y = 32'(longint'(c.a_pos_y) + ($urandom % off) - off / 2);
        c.a_vel_x = $urandom_range(0, 3) == 0 ? rnd32() : 32'($signed($urandom) >>> 8);
        c.a_vel_y = $urandom_range(0, 3) == 0 ? rnd32() : 32'($signed($urandom) >>> 8);
        c.b_vel_x = $urandom_range(0, 3) == 0 ? rnd32() : 32'($signed($urandom) >>> 8);
        c.b_vel_y = $urandom_range(0, 3) == 0 ? rnd32() : 32'($signed($urandom) >>> 8);
        return c;
    endfunction

    function automatic t_in noise_pair();
        t_in c;
        c = IN_W'({rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
                   rnd32(), rnd32(), rnd32()});
        return c;
    endfunction

    // Offer one transaction, idling at random before it unless calm is set
    task automatic offer(input t_in c);
        while (!calm && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= c;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PMIN = 32'h8000_0000;
    localparam logic [30:0] RMAX = 31'h7FFF_FFFF;

    initial begin
        t_in c;
        int  k;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        sent     = 0;
        calm     = 1'b0;
        hold_req = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: coincident centres, far apart, touching, saturation
        offer('{32'd100, 32'd200, 32'd5, -32'sd5, 31'd0, 32'd100, 32'd200, 32'd1, 32'd2, 31'd0});
        offer('{PMIN, PMAX, PMAX, PMIN, RMAX, PMIN, PMAX, PMIN, PMAX, RMAX});
        offer('{PMIN, 32'd0, 32'd0, 32'd0, RMAX, PMAX, 32'd0, 32'd0, 32'd0, RMAX});
        offer('{PMIN, PMIN, 32'd0, 32'd0, RMAX, PMAX, PMAX, 32'd0, 32'd0, RMAX});
        offer('{32'd0, 32'd0, 32'd0, 32'd0, 31'd3, 32'd0, 32'd5, 32'd0, 32'd0, 31'd2});
        offer('{32'd0, 32'd0, 32'd0, 32'd0, 31'd3, 32'd3, 32'd4, 32'd0, 32'd0, 31'd3});
        offer('{32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 32'd1, 32'd0, 32'd0, 32'd0, 31'd0});
        offer('{32'd0, 32'd0, 32'h10000, 32'd0, 31'h10000, 32'h10000, 32'd0,
                -32'sh10000, 32'd0, 31'h10000});
        offer('{32'd0, 32'd0, PMAX, PMAX, 31'h10000, -32'sd1, 32'd1, PMIN, PMIN, 31'h30000});
        offer('{PMAX, PMAX, PMIN, PMAX, RMAX, PMAX - 1, PMAX, PMAX, PMIN, RMAX});
        offer('{PMIN, PMIN, 32'd7, 32'd9, RMAX, PMIN + 5, PMIN + 3, -32'sd7, 32'd0, RMAX});
        offer('{32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 32'd1, 32'd1, 32'd0, 32'd0, 31'h8000});
        offer('{32'd0, 32'd0, 32'd0, 32'd0, 31'h8000, -32'sd1, -32'sd1, 32'd0, 32'd0, 31'd0});
        offer('{32'd50, -32'sd50, PMIN, PMIN, RMAX, -32'sd50, 32'd50, PMAX, PMAX, 31'd1});
        offer('{32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0});

        // Random: mostly overlapping pairs, some noise
        for (k = 0; k < 550; k++) begin
            calm = (k >= 150 && k < 250);
            if (k == 300) hold_req = 1'b1;
            if (k == 420) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            c = ($urandom_range(99) < 80) ? overlap_pair() : noise_pair();
            offer(c);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // Drain
        @(posedge i_clk);
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
